// ===== design/bgt_pkg.sv =====
// bgt_pkg: shared constants, types and helper functions for the bloom / grade /
// tone map block. Used by all modules here but bgt_checker; depends on nothing.
package bgt_pkg;

   localparam int MAX_WIDTH   = 2048;
   localparam int MAX_HEIGHT  = 4096;
   localparam int STORE_ROWS  = 8;
   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int SLOT_BITS   = $clog2(STORE_ROWS);
   localparam int ADDR_BITS   = COL_BITS + SLOT_BITS;
   localparam int STORE_DEPTH = STORE_ROWS * MAX_WIDTH;
   localparam int PIX_BITS    = 24;
   localparam int FRAC_BITS   = 16;
   localparam int SUM_BITS    = 29;
   localparam int WIN_LAST    = 4;
   localparam int WIN_MID     = 2;

   localparam logic [PIX_BITS-1:0]  THRESH   = 24'd52429;   // round(0.8 * 2^16)
   localparam logic [FRAC_BITS:0]   ONE      = 17'd65536;
   localparam logic [19:0]          DIV50_MUL = 20'd671089; // ceil(2^25 / 50)
   localparam logic [21:0]          DIV25_MUL = 22'd2684355; // ceil(2^26 / 25)

   // configuration register indexes
   localparam logic [2:0] CSR_ENABLE   = 3'd0;
   localparam logic [2:0] CSR_STRENGTH = 3'd1;
   localparam logic [2:0] CSR_WIDTH    = 3'd2;
   localparam logic [2:0] CSR_HEIGHT   = 3'd3;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef enum logic [1:0] {CHAN_RED, CHAN_GREEN, CHAN_BLUE} chan_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_WIN, ST_FLUSH, ST_START, ST_BUSY, ST_OUT
   } ctl_state_type;

   typedef enum logic [3:0] {
      LN_IDLE, LN_MUL, LN_DIV25, LN_LOW, LN_ADD, LN_GAIN, LN_SCALE,
      LN_TA, LN_TB, LN_DQ0, LN_DIV, LN_ROUND, LN_DONE
   } lane_state_type;

   typedef struct packed {
      logic                 wr_en;
      logic [ADDR_BITS-1:0] wr_addr;
      logic                 rd_en;
      logic [ADDR_BITS-1:0] rd_addr;
      logic                 rd_center;
      logic                 acc_clear;
      logic                 start;
   } lane_ctl_type;

   typedef struct packed {
      logic load;
      logic bypass;
      logic frame_end;
   } merge_ctl_type;

   // floor(y / 50) for y below 2^19, by reciprocal multiply
   function automatic logic [13:0] div50(input logic [18:0] y);
      logic [44:0] p;
      p = 45'(y) * 45'(DIV50_MUL);
      return p[38:25];
   endfunction

   // floor(y / 25) for y below 2^21, by reciprocal multiply
   function automatic logic [16:0] div25(input logic [20:0] y);
      logic [42:0] p;
      p = 43'(y) * 43'(DIV25_MUL);
      return p[42:26];
   endfunction

endpackage

// ===== design/bgt_lane.sv =====
// bgt_lane: one color channel. Row store memory, 5x5 overbright window sum,
// bloom add, channel gain and the ACES curve with a bit-serial divider. Uses bgt_pkg.
module bgt_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  bgt_pkg::chan_type     chan,
   input  bgt_pkg::lane_ctl_type ctl,
   input  logic [23:0]           wr_data,
   input  logic [15:0]           strength,
   output logic [23:0]           center,
   output logic [23:0]           result,
   output logic                  done
);
   import bgt_pkg::*;

   logic [PIX_BITS-1:0] mem [STORE_DEPTH];
   logic [PIX_BITS-1:0] rdata_ff;
   logic                rd_vld_ff, rd_ctr_ff;
   logic [SUM_BITS-1:0] sum_ff;
   logic [PIX_BITS-1:0] center_ff;

   lane_state_type state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [34:0] dq_ff, dq_in;
   logic [4:0]  drem_ff, drem_in;
   logic [13:0] gain_ff, gain_in;
   logic        bzero_ff, bzero_in;
   logic [30:0] v_ff, v_in;
   logic [45:0] p2_ff, p2_in;
   logic [18:0] x_ff, x_in;
   logic        sat_ff, sat_in;
   logic [27:0] a_ff, a_in, b_ff, b_in;
   logic [46:0] n_ff, n_in, d_ff, d_in, r_ff, r_in;
   logic [17:0] q_ff, q_in;
   logic [16:0] res_ff, res_in;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) mem[ctl.wr_addr] <= wr_data;
      if (ctl.rd_en) rdata_ff <= mem[ctl.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         rd_ctr_ff <= 1'b0;
         state_ff  <= LN_IDLE;
         cnt_ff    <= '0;
      end else begin
         rd_vld_ff <= ctl.rd_en;
         rd_ctr_ff <= ctl.rd_center;
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
      end
   end

   // window accumulation, one tap per cycle
   always_ff @(posedge clock) begin
      if (ctl.acc_clear) begin
         sum_ff <= '0;
      end else if (rd_vld_ff) begin
         if (rdata_ff > THRESH) sum_ff <= sum_ff + SUM_BITS'(rdata_ff - THRESH);
         if (rd_ctr_ff) center_ff <= rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff <= dq_in;   drem_ff <= drem_in; gain_ff <= gain_in; bzero_ff <= bzero_in;
      v_ff  <= v_in;    p2_ff   <= p2_in;   x_ff    <= x_in;    sat_ff   <= sat_in;
      a_ff  <= a_in;    b_ff    <= b_in;    n_ff    <= n_in;    d_ff     <= d_in;
      r_ff  <= r_in;    q_ff    <= q_in;    res_ff  <= res_in;
   end

   always_comb begin
      logic [45:0] mul1;
      logic [13:0] dec;
      logic        ge;
      logic [33:0] xs;
      logic [47:0] rr;
      logic [18:0] qr;
      logic [16:0] q25;
      logic [18:0] r19;

      state_in = state_ff; cnt_in = cnt_ff;
      dq_in = dq_ff; drem_in = drem_ff; gain_in = gain_ff; bzero_in = bzero_ff;
      v_in = v_ff; p2_in = p2_ff; x_in = x_ff; sat_in = sat_ff;
      a_in = a_ff; b_in = b_ff; n_in = n_ff; d_in = d_ff;
      r_in = r_ff; q_in = q_ff; res_in = res_ff;
      mul1 = 46'(sum_ff) * 46'(strength) + 46'd25600;
      dec  = '0;
      ge   = 1'b0;
      xs   = '0;
      rr   = '0;
      qr   = '0;
      q25  = '0;
      r19  = '0;

      case (state_ff)
         LN_IDLE, LN_DONE: begin
            if (ctl.start) state_in = LN_MUL;
         end
         LN_MUL: begin
            // bloom = round(sum * s / 51200) = floor(((sum*s + 25600) >> 11) / 25)
            dq_in    = mul1[45:11];
            drem_in  = '0;
            bzero_in = 1'b0;
            case (chan)
               CHAN_RED: gain_in = 14'd4096 + div50(19'(strength) * 19'd4 + 19'd25);
               CHAN_BLUE: begin
                  dec = div50(19'(strength) * 19'd3 + 19'd25);
                  bzero_in = (dec >= 14'd4096);
                  gain_in  = 14'd4096 - dec;
               end
               default: gain_in = 14'd4096;
            endcase
            state_in = LN_DIV25;
         end
         LN_DIV25: begin
            // upper 19 bits: quotient and remainder by 25
            q25 = div25(21'(dq_ff[34:16]));
            r19 = dq_ff[34:16] - 19'(q25) * 19'd25;
            drem_in = r19[4:0];
            dq_in   = {4'b0000, q25[14:0], dq_ff[15:0]};
            state_in = LN_LOW;
         end
         LN_LOW: begin
            // remainder carried into the low 16 bits
            q25 = div25({drem_ff, dq_ff[15:0]});
            dq_in = 35'({dq_ff[30:16], 16'h0000}) + 35'(q25);
            state_in = LN_ADD;
         end
         LN_ADD: begin
            v_in = 31'(center_ff) + 31'(dq_ff[29:0]);
            state_in = LN_GAIN;
         end
         LN_GAIN: begin
            p2_in = 46'(v_ff) * 46'(gain_ff) + 46'd2048;
            state_in = LN_SCALE;
         end
         LN_SCALE: begin
            xs = p2_ff[45:12];
            if (chan == CHAN_RED && xs > 34'(20 * 65536)) xs = 34'(20 * 65536);
            if (chan == CHAN_BLUE && bzero_ff) xs = '0;
            sat_in = (xs >= 34'(8 * 65536));
            x_in   = xs[18:0];
            state_in = LN_TA;
         end
         LN_TA: begin
            a_in = 28'(x_ff) * 28'd251 + 28'(3 * 65536);
            b_in = 28'(x_ff) * 28'd243 + 28'(59 * 65536);
            state_in = LN_TB;
         end
         LN_TB: begin
            n_in = 47'(x_ff) * 47'(a_ff);
            d_in = 47'(x_ff) * 47'(b_ff) + (47'd14 << 32);
            state_in = LN_DQ0;
         end
         LN_DQ0: begin
            // curve stays below 2, so the integer part is one bit
            ge     = (n_ff >= d_ff);
            r_in   = ge ? n_ff - d_ff : n_ff;
            q_in   = 18'(ge);
            cnt_in = 6'd17;
            state_in = LN_DIV;
         end
         LN_DIV: begin
            rr = {r_ff, 1'b0};
            ge = (rr >= {1'b0, d_ff});
            r_in = ge ? 47'(rr - {1'b0, d_ff}) : rr[46:0];
            q_in = {q_ff[16:0], ge};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) state_in = LN_ROUND;
         end
         LN_ROUND: begin
            qr = (19'(q_ff) + 19'd1) >> 1;
            if (sat_ff || qr > 19'(ONE)) res_in = ONE;
            else res_in = qr[16:0];
            state_in = LN_DONE;
         end
         default: state_in = LN_IDLE;
      endcase
   end

   assign center = center_ff;
   assign result = 24'(res_ff);
   assign done   = (state_ff == LN_DONE);

endmodule

// ===== design/bgt_merge.sv =====
// bgt_merge: joins the three lane results, or in bypass the center pixels, into
// one output beat and holds it in the output register until taken. Uses bgt_pkg.
module bgt_merge (
   input  logic                   clock,
   input  logic                   reset,
   input  bgt_pkg::merge_ctl_type mrg,
   input  logic [2:0][23:0]       lane_res,
   input  logic [2:0][23:0]       lane_mid,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic [23:0]            rsp_red_out,
   output logic [23:0]            rsp_green_out,
   output logic [23:0]            rsp_blue_out,
   output logic                   rsp_frame_end,
   output logic                   busy
);
   import bgt_pkg::*;

   logic        valid_ff, valid_in;
   logic [23:0] red_ff, green_ff, blue_ff;
   logic        end_ff;
   logic [2:0][23:0] px;

   // bypass hands back the raw center pixel
   assign px = mrg.bypass ? lane_mid : lane_res;

   always_comb begin
      valid_in = valid_ff;
      if (valid_ff && !rsp_stall) valid_in = 1'b0;
      if (mrg.load) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (mrg.load) begin
         red_ff   <= px[CHAN_RED];
         green_ff <= px[CHAN_GREEN];
         blue_ff  <= px[CHAN_BLUE];
         end_ff   <= mrg.frame_end;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_red_out   = red_ff;
   assign rsp_green_out = green_ff;
   assign rsp_blue_out  = blue_ff;
   assign rsp_frame_end = end_ff;
   assign busy          = valid_ff;

endmodule

// ===== design/bloom_grade_tonemap.sv =====
// bloom_grade_tonemap: top level. Counters, window address sequencer, three
// channel lanes and the output merge. Uses bgt_pkg, bgt_lane, bgt_merge.
//
// Pixels arrive in raster order; each is written to an eight-row store as it is
// accepted. An item that releases an output pixel (two rows plus two pixels
// behind the input, or a drain beat once the frame is in) holds the input
// through the accept, 25 serial window reads from the single read port
// of each channel's row store, the flush and start states that finish the sum,
// the per-lane arithmetic (a two-step reciprocal divide by 25 for the bloom
// average, then gain and an 18-step divide in the tone curve) and the load of
// the output register, which waits while the previous result is still there.
// The three channels run as parallel lanes. An item that releases nothing
// leaves the block idle.
// Register writes are taken only while the block is idle; writing width or
// height restarts the frame. With enable low or zero strength the center pixel
// comes out unchanged at the same latency.
module bloom_grade_tonemap (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [23:0] req_red_in,
   input  logic [23:0] req_green_in,
   input  logic [23:0] req_blue_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [23:0] rsp_red_out,
   output logic [23:0] rsp_green_out,
   output logic [23:0] rsp_blue_out,
   output logic        rsp_frame_end,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import bgt_pkg::*;

   ctl_state_type state_ff, state_in;
   logic        enable_ff, enable_in;
   logic [15:0] strength_ff, strength_in;
   logic [11:0] fw_ff, fw_in;
   logic [12:0] fh_ff, fh_in;
   logic [10:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [11:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [12:0] lead_ff, lead_in;
   logic        done_ff, done_in;
   logic [2:0]  wx_ff, wx_in, wy_ff, wy_in;

   logic [11:0] eff_w;
   logic [12:0] eff_h;
   logic        accept, is_pix, last, mrg_busy, all_done;
   logic [ADDR_BITS-1:0] win_addr;
   lane_ctl_type  lane_ctl;
   merge_ctl_type mrg;
   logic [2:0][23:0] lane_res, lane_mid;
   logic [2:0]       lane_done;

   always_comb begin
      eff_w = fw_ff;
      if (fw_ff < 12'd3) eff_w = 12'd3;
      else if (fw_ff > 12'(MAX_WIDTH)) eff_w = 12'(MAX_WIDTH);
      eff_h = fh_ff;
      if (fh_ff < 13'd3) eff_h = 13'd3;
      else if (fh_ff > 13'(MAX_HEIGHT)) eff_h = 13'(MAX_HEIGHT);
   end

   assign csr_ready = (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE) || csr_valid;
   assign accept    = req_valid && !req_stall;
   assign is_pix    = (req_op == OP_PIXEL) && !done_ff;
   assign last      = ({1'b0, out_row_ff} == eff_h - 13'd1) &&
                      ({1'b0, out_col_ff} == eff_w - 12'd1);
   assign all_done  = &lane_done;

   // mirrored window address, edge not repeated
   always_comb begin
      logic signed [14:0] rs, rm, hs;
      logic signed [13:0] cs, cm, ws;
      rs = $signed({3'b000, out_row_ff}) + $signed({12'b0, wy_ff}) - 15'sd2;
      hs = $signed({2'b00, eff_h});
      if (rs < 0) rm = -rs;
      else if (rs >= hs) rm = (hs <<< 1) - 15'sd2 - rs;
      else rm = rs;
      cs = $signed({3'b000, out_col_ff}) + $signed({11'b0, wx_ff}) - 14'sd2;
      ws = $signed({2'b00, eff_w});
      if (cs < 0) cm = -cs;
      else if (cs >= ws) cm = (ws <<< 1) - 14'sd2 - cs;
      else cm = cs;
      win_addr = {rm[SLOT_BITS-1:0], cm[COL_BITS-1:0]};
   end

   always_comb begin
      logic [11:0] col_nx;
      logic [12:0] row_nx, lead_nx, need;
      logic        restart;

      state_in = state_ff; enable_in = enable_ff; strength_in = strength_ff;
      fw_in = fw_ff; fh_in = fh_ff;
      in_col_in = in_col_ff; in_row_in = in_row_ff;
      out_col_in = out_col_ff; out_row_in = out_row_ff;
      lead_in = lead_ff; done_in = done_ff; wx_in = wx_ff; wy_in = wy_ff;
      lane_ctl = '0;
      mrg = '0;
      restart = 1'b0;
      col_nx  = '0;
      row_nx  = '0;
      lead_nx = lead_ff + 13'd1;
      need    = {eff_w, 1'b0} + 13'd3;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ENABLE:   enable_in = csr_data[0];
            CSR_STRENGTH: strength_in = csr_data;
            CSR_WIDTH: begin
               fw_in = csr_data[11:0];
               restart = 1'b1;
            end
            CSR_HEIGHT: begin
               fh_in = csr_data[12:0];
               restart = 1'b1;
            end
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               lane_ctl.acc_clear = 1'b1;
               if (is_pix) begin
                  lane_ctl.wr_en   = 1'b1;
                  lane_ctl.wr_addr = {in_row_ff[SLOT_BITS-1:0], in_col_ff};
                  col_nx = {1'b0, in_col_ff} + 12'd1;
                  if (col_nx >= eff_w) begin
                     in_col_in = '0;
                     row_nx = {1'b0, in_row_ff} + 13'd1;
                     in_row_in = row_nx[11:0];
                     if (row_nx >= eff_h) done_in = 1'b1;
                  end else begin
                     in_col_in = col_nx[10:0];
                  end
                  if (lead_nx >= need) state_in = ST_WIN;
                  else lead_in = lead_nx;
               end else if (done_ff) begin
                  state_in = ST_WIN;
               end
            end
         end
         ST_WIN: begin
            lane_ctl.rd_en     = 1'b1;
            lane_ctl.rd_addr   = win_addr;
            lane_ctl.rd_center = (wx_ff == 3'(WIN_MID)) && (wy_ff == 3'(WIN_MID));
            if (wx_ff == 3'(WIN_LAST)) begin
               wx_in = '0;
               if (wy_ff == 3'(WIN_LAST)) begin
                  wy_in = '0;
                  state_in = ST_FLUSH;
               end else begin
                  wy_in = wy_ff + 3'd1;
               end
            end else begin
               wx_in = wx_ff + 3'd1;
            end
         end
         ST_FLUSH: state_in = ST_START;
         ST_START: begin
            lane_ctl.start = 1'b1;
            state_in = ST_BUSY;
         end
         ST_BUSY: begin
            if (all_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!mrg_busy) begin
               mrg.load      = 1'b1;
               mrg.bypass    = !enable_ff || (strength_ff == 16'd0);
               mrg.frame_end = last;
               if (last) begin
                  restart = 1'b1;
               end else begin
                  col_nx = {1'b0, out_col_ff} + 12'd1;
                  if (col_nx >= eff_w) begin
                     out_col_in = '0;
                     out_row_in = out_row_ff + 12'd1;
                  end else begin
                     out_col_in = col_nx[10:0];
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (restart) begin
         in_col_in = '0; in_row_in = '0; out_col_in = '0; out_row_in = '0;
         lead_in = '0; done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         enable_ff <= 1'b0;
         strength_ff <= '0;
         fw_ff <= 12'd640;
         fh_ff <= 13'd480;
         in_col_ff <= '0; in_row_ff <= '0; out_col_ff <= '0; out_row_ff <= '0;
         lead_ff <= '0; done_ff <= 1'b0; wx_ff <= '0; wy_ff <= '0;
      end else begin
         state_ff <= state_in;
         enable_ff <= enable_in;
         strength_ff <= strength_in;
         fw_ff <= fw_in;
         fh_ff <= fh_in;
         in_col_ff <= in_col_in; in_row_ff <= in_row_in;
         out_col_ff <= out_col_in; out_row_ff <= out_row_in;
         lead_ff <= lead_in; done_ff <= done_in; wx_ff <= wx_in; wy_ff <= wy_in;
      end
   end

   bgt_lane u_lane_red (
      .clock(clock), .reset(reset), .chan(CHAN_RED), .ctl(lane_ctl),
      .wr_data(req_red_in), .strength(strength_ff),
      .center(lane_mid[CHAN_RED]), .result(lane_res[CHAN_RED]),
      .done(lane_done[CHAN_RED])
   );

   bgt_lane u_lane_green (
      .clock(clock), .reset(reset), .chan(CHAN_GREEN), .ctl(lane_ctl),
      .wr_data(req_green_in), .strength(strength_ff),
      .center(lane_mid[CHAN_GREEN]), .result(lane_res[CHAN_GREEN]),
      .done(lane_done[CHAN_GREEN])
   );

   bgt_lane u_lane_blue (
      .clock(clock), .reset(reset), .chan(CHAN_BLUE), .ctl(lane_ctl),
      .wr_data(req_blue_in), .strength(strength_ff),
      .center(lane_mid[CHAN_BLUE]), .result(lane_res[CHAN_BLUE]),
      .done(lane_done[CHAN_BLUE])
   );

   bgt_merge u_merge (
      .clock(clock), .reset(reset), .mrg(mrg),
      .lane_res(lane_res), .lane_mid(lane_mid),
      .rsp_stall(rsp_stall), .rsp_valid(rsp_valid),
      .rsp_red_out(rsp_red_out), .rsp_green_out(rsp_green_out),
      .rsp_blue_out(rsp_blue_out), .rsp_frame_end(rsp_frame_end),
      .busy(mrg_busy)
   );

endmodule

// ===== design/bgt_checker.sv =====
// bgt_checker: port-level checks for bloom_grade_tonemap, attached by bind.
// Sees only the top-level ports; no package needed.
module bgt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_op,
   input logic [23:0] req_red_in,
   input logic [23:0] req_green_in,
   input logic [23:0] req_blue_in,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [23:0] rsp_red_out,
   input logic [23:0] rsp_green_out,
   input logic [23:0] rsp_blue_out,
   input logic        rsp_frame_end,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [2:0]  csr_index,
   input logic [15:0] csr_data
);

   // nothing comes out in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // a register write beat always wins over a pixel beat
   a_csr_first: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> req_stall)
      else $error("input taken while a register write is pending");

   // a result only appears after the block has been busy working on it
   a_out_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result beat without a preceding busy cycle");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_red_out) &&
      $stable(rsp_green_out) && $stable(rsp_blue_out) && $stable(rsp_frame_end))
      else $error("stalled result beat changed");

endmodule

bind bloom_grade_tonemap bgt_checker u_bgt_checker (.*);
